### hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} sha_out_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} sha_ctl_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [255:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		round_k = k;
	endfunction

endpackage

### hdl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Iterative SHA-256 compression: one round per cycle over a 16-word
// message schedule window, then the final add into the hash state.
// ----------------------------------------------------------------------------
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                init,
	input  logic [511:0]        block,
	output logic [255:0]        hash,
	output sha_pkg::sha_ctl_t   ctl
);
	import sha_pkg::*;

	logic [255:0] h_q;
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;
	logic         busy_q;
	logic         done_q;

	logic [31:0] e, a, big1, ch, t1, big0, maj, t2, wn, s0, s1;

	always_comb begin
		e    = v_q[4];
		a    = v_q[0];
		big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
		ch   = (e & v_q[5]) ^ (~e & v_q[6]);
		t1   = v_q[7] + big1 + ch + round_k(rnd_q) + w_q[0];
		big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
		maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = big0 + maj;
		s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn   = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= H_INIT;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (init) begin
				h_q <= H_INIT;
			end
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					for (int i = 0; i < 8; i++) begin
						h_q[255-32*i -: 32] <= h_q[255-32*i -: 32] +
							((i == 0) ? t1 + t2 : (i == 4) ? v_q[3] + t1 : v_q[i-1]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[255-32*i -: 32];
			for (int i = 0; i < 16; i++) w_q[i] <= block[511-32*i -: 32];
		end else if (busy_q) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

	assign hash      = h_q;
	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;

endmodule

### hdl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 over a byte stream with a word-serial digest output.
// ----------------------------------------------------------------------------
// An absorb beat stores one byte in the buffer; the 64th byte of a block
// also starts the compression, and input is then not ready while the
// single shared round unit runs one round per cycle. A finish beat pads
// the buffer and compresses once, or twice when more than 55 bytes were
// buffered, then presents the eight digest words as eight output beats;
// input is not ready until the last one is taken. Afterward the hash state
// returns to the initial values.
module sha256_stream_hasher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sha_pkg::sha_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sha_pkg::sha_out_t  out_data
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COMP  = 3'd1;
	localparam logic [2:0] ST_PAD2  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]   state_q;
	logic [31:0]  buf_q [16];
	logic [5:0]   fill_q;
	logic [63:0]  msg_q;
	logic [2:0]   widx_q;
	logic         go_q;
	logic         start;
	logic         init;
	logic [511:0] block;
	logic [255:0] hash;
	sha_ctl_t     ctl;
	logic         acc;
	logic         fin;
	logic [63:0]  bits;

	assign acc  = in_valid && in_ready;
	assign fin  = acc && (in_data.op == OP_FINISH);
	assign bits = {msg_q[60:0], 3'b000};
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		for (int i = 0; i < 16; i++) block[511-32*i -: 32] = buf_q[i];
	end

	// buffer update and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			msg_q   <= '0;
			widx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && in_data.op == OP_ABSORB) begin
						fill_q <= fill_q + 6'd1;
						msg_q  <= msg_q + 64'd1;
						if (fill_q == 6'd63) state_q <= ST_COMP;
					end else if (fin) begin
						state_q <= (fill_q >= 6'd56) ? ST_PAD2 : ST_FIN;
					end
				end
				ST_COMP: if (ctl.done) state_q <= ST_IDLE;
				ST_PAD2: if (ctl.done) state_q <= ST_FIN;
				ST_FIN: if (ctl.done) begin
					state_q <= ST_EMIT;
					widx_q  <= '0;
				end
				ST_EMIT: if (out_ready) begin
					widx_q <= widx_q + 3'd1;
					if (widx_q == 3'd7) begin
						state_q <= ST_IDLE;
						fill_q  <= '0;
						msg_q   <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_data.op == OP_ABSORB) begin
			buf_q[fill_q[5:2]][31-8*fill_q[1:0] -: 8] <= in_data.data_byte;
		end else if (fin) begin
			for (int i = 0; i < 64; i++) begin
				if (i == int'(fill_q)) begin
					buf_q[i/4][31-8*(i%4) -: 8] <= PAD_BYTE;
				end else if (i > int'(fill_q)) begin
					if (fill_q < LEN_POS && i >= 56)
						buf_q[i/4][31-8*(i%4) -: 8] <= bits[63-8*(i-56) -: 8];
					else
						buf_q[i/4][31-8*(i%4) -: 8] <= 8'h00;
				end
			end
		end else if (state_q == ST_PAD2 && ctl.done) begin
			for (int i = 0; i < 14; i++) buf_q[i] <= 32'h0;
			buf_q[14] <= bits[63:32];
			buf_q[15] <= bits[31:0];
		end
	end

	// start is registered, so it is raised once the buffer has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
		end else begin
			go_q <= (acc && in_data.op == OP_ABSORB && fill_q == 6'd63) || fin ||
				(state_q == ST_PAD2 && ctl.done);
		end
	end

	assign start = go_q;
	assign init  = (state_q == ST_EMIT) && out_ready && (widx_q == 3'd7);

	sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.init   (init),
		.block  (block),
		.hash   (hash),
		.ctl    (ctl)
	);

	assign out_valid            = (state_q == ST_EMIT);
	assign out_data.digest_word = hash[255-32*widx_q -: 32];
	assign out_data.word_index  = widx_q;
	assign out_data.last        = (widx_q == 3'd7);

	ap_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.busy |-> !in_ready) else $error("input accepted during compression");
	ap_emit_idle_core: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !ctl.busy) else $error("digest shown while core busy");
	ap_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_data.last) |=> in_ready)
		else $error("no return to idle after last word");

endmodule

### tb/tb_sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher
// Self-checking bench: drives absorb/finish beats, predicts SHA-256 digests.
// ----------------------------------------------------------------------------
// Directed and random messages are hashed by a local SHA-256
// predictor; each output beat is checked against the oldest expected word.
module tb_sha256_stream_hasher;
	timeunit 1ns;
	timeprecision 1ps;
	import sha_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sha_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sha_out_t out_data;

	sha256_stream_hasher u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] IV_TAB [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	// predictor state
	logic [31:0] st_hash [8];
	logic [7:0] st_buf [64];
	int unsigned st_fill;
	logic [63:0] st_len;

	sha_in_t pending_beats [$];
	sha_out_t digest_words [$];
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	bit idle_enable = 1'b1;
	bit sink_hold = 1'b0;
	int unsigned src_gap = 0;
	int unsigned sink_gap = 0;

	function automatic logic [31:0] ror(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_buf();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {st_buf[4*i], st_buf[4*i+1], st_buf[4*i+2], st_buf[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		v = st_hash;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			st_hash[i] += v[i];
	endtask

	task automatic restart_msg();
		st_hash = IV_TAB;
		st_fill = 0;
		st_len = '0;
	endtask

	task automatic predict_digest(sha_in_t b);
		logic [63:0] bits;
		int unsigned pos;
		sha_out_t o;
		if (b.op == OP_ABSORB) begin
			st_buf[st_fill] = b.data_byte;
			st_fill++;
			st_len++;
			if (st_fill == 64) begin
				compress_buf();
				st_fill = 0;
			end
		end else begin
			bits = st_len << 3;
			pos = st_fill;
			st_buf[pos] = PAD_BYTE;
			pos++;
			if (pos > 56) begin
				while (pos < 64) st_buf[pos++] = 8'h00;
				compress_buf();
				pos = 0;
			end
			while (pos < 56) st_buf[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				st_buf[63-i] = bits[8*i +: 8];
			compress_buf();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = st_hash[i];
				o.word_index = 3'(i);
				o.last = (i == 7);
				digest_words.push_back(o);
			end
			restart_msg();
		end
	endtask

	task automatic queue_msg(int unsigned nbytes, int unsigned mode);
		sha_in_t b;
		for (int unsigned i = 0; i < nbytes; i++) begin
			b.op = OP_ABSORB;
			case (mode)
				0: b.data_byte = 8'h00;
				1: b.data_byte = 8'hff;
				default: b.data_byte = 8'($urandom);
			endcase
			pending_beats.push_back(b);
		end
		b.op = OP_FINISH;
		b.data_byte = 8'($urandom);
		pending_beats.push_back(b);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready)
			predict_digest(in_data);
		if (!in_valid || in_ready) begin
			if (in_valid && in_ready)
				void'(pending_beats.pop_front());
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_beats[0];
				if (idle_enable && $urandom_range(0, 7) == 0)
					src_gap <= $urandom_range(1, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (digest_words.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected digest beat: %h idx %0d last %b",
						out_data.digest_word, out_data.word_index, out_data.last);
			end else begin
				if (out_data !== digest_words[0]) begin
					err_count++;
					if (err_count <= 10)
						$display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
							digest_words[0].digest_word, digest_words[0].word_index,
							digest_words[0].last, out_data.digest_word,
							out_data.word_index, out_data.last);
				end
				void'(digest_words.pop_front());
			end
		end
		if (sink_hold) begin
			out_ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_enable && $urandom_range(0, 5) == 0)
				sink_gap <= $urandom_range(1, 4);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("sha256_stream_hasher regression: fail");
			$finish;
		end
	end

	task automatic drain_all();
		while (pending_beats.size() > 0 || in_valid || digest_words.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned n;
		restart_msg();
		for (int i = 0; i < 64; i++) st_buf[i] = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty message, boundary lengths, all-zero and all-one bytes
		queue_msg(0, 2);
		queue_msg(3, 2);
		queue_msg(55, 0);
		queue_msg(56, 1);
		drain_all();
		queue_msg(63, 2);
		queue_msg(64, 1);
		drain_all();

		// long receiver hold while the sender keeps offering
		sink_hold = 1'b1;
		queue_msg(1, 2);
		queue_msg(2, 2);
		queue_msg(0, 2);
		repeat (300) @(posedge clk);
		sink_hold = 1'b0;
		drain_all();

		// random messages, mostly short, a few spanning two blocks
		n = 0;
		while (n < 30) begin
			automatic int unsigned len = ($urandom_range(0, 9) == 0) ?
				$urandom_range(56, 72) : $urandom_range(0, 20);
			queue_msg(len, 2);
			n += len + 1;
			if ($urandom_range(0, 7) == 0)
				drain_all();
		end
		drain_all();

		// final stretch with no idling
		idle_enable = 1'b0;
		n = 0;
		while (n < 30) begin
			automatic int unsigned len = $urandom_range(0, 20);
			queue_msg(len, 2);
			n += len + 1;
		end
		drain_all();
		repeat (200) @(posedge clk);

		if (err_count == 0 && digest_words.size() == 0)
			$display("sha256_stream_hasher regression: pass");
		else
			$display("sha256_stream_hasher regression: fail");
		$finish;
	end
endmodule
